@@ rtl/core/pidaw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidaw_pkg: shared types and constants of the PID controller
// Widths of the data path, beat payloads, register indexes, multiplier
// operand selects and the command group from controller to data path.
// ----------------------------------------------------------------------------
package pidaw_pkg;

	localparam int DATA_WIDTH     = 16;
	localparam int GAIN_FRAC_BITS = 16;
	localparam int GAIN_WIDTH     = 24;
	localparam int ACC_WIDTH      = 32;

	localparam int ERR_WIDTH  = DATA_WIDTH + 1;
	localparam int DIFF_WIDTH = DATA_WIDTH + 2;
	localparam int MULB_WIDTH = (ACC_WIDTH > DIFF_WIDTH) ? ACC_WIDTH : DIFF_WIDTH;
	localparam int PROD_WIDTH = GAIN_WIDTH + MULB_WIDTH;
	localparam int SUM_WIDTH  = PROD_WIDTH + 2;
	localparam int Y_WIDTH    = SUM_WIDTH - GAIN_FRAC_BITS;
	localparam int ASUM_WIDTH = ((ACC_WIDTH > ERR_WIDTH) ? ACC_WIDTH : ERR_WIDTH) + 1;

	localparam int CFG_IDX_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH = (GAIN_WIDTH > DATA_WIDTH) ? GAIN_WIDTH : DATA_WIDTH;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_KP = CFG_IDX_WIDTH'(0);
	localparam logic [CFG_IDX_WIDTH-1:0] REG_KI = CFG_IDX_WIDTH'(1);
	localparam logic [CFG_IDX_WIDTH-1:0] REG_KD = CFG_IDX_WIDTH'(2);
	localparam logic [CFG_IDX_WIDTH-1:0] REG_LO = CFG_IDX_WIDTH'(3);
	localparam logic [CFG_IDX_WIDTH-1:0] REG_HI = CFG_IDX_WIDTH'(4);

	localparam logic [1:0] STATUS_WITHIN = 2'd0;
	localparam logic [1:0] STATUS_HIGH   = 2'd1;
	localparam logic [1:0] STATUS_LOW    = 2'd2;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] target_value;
		logic signed [DATA_WIDTH-1:0] measured_value;
	} sample_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] drive_value;
		logic [1:0]                   clamp_status;
	} drive_t;

	typedef struct packed {
		logic signed [GAIN_WIDTH-1:0] kp;
		logic signed [GAIN_WIDTH-1:0] ki;
		logic signed [GAIN_WIDTH-1:0] kd;
		logic signed [DATA_WIDTH-1:0] lo;
		logic signed [DATA_WIDTH-1:0] hi;
	} cfg_t;

	typedef enum logic [1:0] {
		MUL_P,
		MUL_D,
		MUL_I
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     pd_load;
		logic     pd_add;
		logic     trial_en;
		logic     acc_en;
		logic     out_load;
	} cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/pid_controller_antiwindup.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_antiwindup: discrete PID controller with clamping anti-windup
// Takes a target and a measured value per beat and returns one clamped drive
// value with its clamp status.
// ----------------------------------------------------------------------------
// Each sample beat yields exactly one drive beat. A sample is taken when the
// input side is idle; its result is loaded into the output register after the
// P, D, I, trial, accumulate, second I and final states, and the next sample
// is taken only after that load. This schedule is set by the single shared 24
// by 32 bit gain multiplier, which forms the P and D products, the integral
// term with the old accumulator for the anti-windup test, and the integral
// term again with the updated sum. A result waiting in the output register
// does not stop the next sample from being taken; only the final load waits
// for the output register to free up. The error accumulator saturates at the
// 32-bit signed range. When the trial output sits at or beyond a limit and
// the error pushes further out, the accumulator is left unchanged. Gains are
// signed Q8.16, where the integral gain already includes the sample period
// and the derivative gain is already divided by it. Sums are floored to
// integers. A drive value equal to a limit reports "within limits"; if the
// lower limit exceeds the upper one, the lower test is applied first. The user
// is to write configuration only while the block is idle; the block does not
// enforce this. Writes to indexes beyond the last register are ignored.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                sample_valid,
	output logic                                     sample_stall,
	input  wire pidaw_pkg::sample_t                  sample,
	output logic                                     drive_valid,
	input  wire logic                                drive_stall,
	output pidaw_pkg::drive_t                        drive,
	input  wire logic                                cfg_we,
	input  wire logic [pidaw_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  wire logic [pidaw_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

	pidaw_pkg::cfg_t cfg;
	pidaw_pkg::cmd_t cmd;

	// Gain and limit registers.
	pidaw_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The sequencer walks one sample through the multiplier schedule and
	// tracks whether the output register holds an undelivered beat.
	pidaw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.drive_valid  (drive_valid),
		.drive_stall  (drive_stall),
		.cmd          (cmd)
	);

	// Error, derivative difference, shared multiplier, accumulator, clamp.
	pidaw_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.sample (sample),
		.drive  (drive)
	);

endmodule
`default_nettype wire

@@ rtl/core/pidaw_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidaw_regs: configuration registers
// Gains and output limits, written through a plain write port.
// ----------------------------------------------------------------------------
module pidaw_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [pidaw_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
	input  wire logic [pidaw_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
	output pidaw_pkg::cfg_t                          cfg
);

	pidaw_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp <= '0;
			cfg_q.ki <= '0;
			cfg_q.kd <= '0;
			cfg_q.lo <= '0;
			cfg_q.hi <= {1'b0, {(pidaw_pkg::DATA_WIDTH-1){1'b1}}};
		end else if (cfg_we) begin
			// Indexes beyond the last register are ignored.
			unique case (cfg_index)
				pidaw_pkg::REG_KP: cfg_q.kp <= cfg_data[pidaw_pkg::GAIN_WIDTH-1:0];
				pidaw_pkg::REG_KI: cfg_q.ki <= cfg_data[pidaw_pkg::GAIN_WIDTH-1:0];
				pidaw_pkg::REG_KD: cfg_q.kd <= cfg_data[pidaw_pkg::GAIN_WIDTH-1:0];
				pidaw_pkg::REG_LO: cfg_q.lo <= cfg_data[pidaw_pkg::DATA_WIDTH-1:0];
				pidaw_pkg::REG_HI: cfg_q.hi <= cfg_data[pidaw_pkg::DATA_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ rtl/core/pidaw_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidaw_ctrl: sequencer of the PID data path
// Steps one sample through the shared multiplier and owns the output valid.
// ----------------------------------------------------------------------------
module pidaw_ctrl (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     sample_valid,
	output logic          sample_stall,
	output logic          drive_valid,
	input  wire logic     drive_stall,
	output pidaw_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_I,
		ST_TRIAL,
		ST_ACC,
		ST_MUL_I2,
		ST_FINAL
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !drive_stall;

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = pidaw_pkg::MUL_P;
		sample_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = sample_valid;
			end
			ST_MUL_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pidaw_pkg::MUL_P;
			end
			ST_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pidaw_pkg::MUL_D;
				cmd.pd_load = 1'b1;
			end
			ST_MUL_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pidaw_pkg::MUL_I;
				cmd.pd_add  = 1'b1;
			end
			ST_TRIAL: begin
				cmd.trial_en = 1'b1;
			end
			ST_ACC: begin
				cmd.acc_en = 1'b1;
			end
			ST_MUL_I2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pidaw_pkg::MUL_I;
			end
			ST_FINAL: begin
				cmd.out_load = out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!drive_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:   if (sample_valid) state_q <= ST_MUL_P;
				ST_MUL_P:  state_q <= ST_MUL_D;
				ST_MUL_D:  state_q <= ST_MUL_I;
				ST_MUL_I:  state_q <= ST_TRIAL;
				ST_TRIAL:  state_q <= ST_ACC;
				ST_ACC:    state_q <= ST_MUL_I2;
				ST_MUL_I2: state_q <= ST_FINAL;
				ST_FINAL:  if (out_free) state_q <= ST_IDLE;
			endcase
		end
	end

	assign drive_valid = out_valid_q;

endmodule
`default_nettype wire

@@ rtl/core/pidaw_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidaw_datapath: error, shared multiplier, accumulator and clamp
// One registered gain multiplier serves the P, D and both I products.
// ----------------------------------------------------------------------------
module pidaw_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pidaw_pkg::cmd_t    cmd,
	input  wire pidaw_pkg::cfg_t    cfg,
	input  wire pidaw_pkg::sample_t sample,
	output pidaw_pkg::drive_t       drive
);

	localparam int EW = pidaw_pkg::ERR_WIDTH;
	localparam int DW = pidaw_pkg::DIFF_WIDTH;
	localparam int BW = pidaw_pkg::MULB_WIDTH;
	localparam int PW = pidaw_pkg::PROD_WIDTH;
	localparam int SW = pidaw_pkg::SUM_WIDTH;
	localparam int YW = pidaw_pkg::Y_WIDTH;
	localparam int AW = pidaw_pkg::ACC_WIDTH;
	localparam int XW = pidaw_pkg::ASUM_WIDTH;

	localparam logic signed [XW-1:0] ACC_MAX = XW'({1'b0, {(AW-1){1'b1}}});
	localparam logic signed [XW-1:0] ACC_MIN = -ACC_MAX - XW'(1);

	logic signed [EW-1:0] err_q, prev_err_q, err_new;
	logic signed [DW-1:0] diff_q;
	logic signed [AW-1:0] acc_q;
	logic signed [PW-1:0] prod_q, pd_q;
	logic                 hold_q;
	pidaw_pkg::drive_t    drive_q;

	logic signed [pidaw_pkg::GAIN_WIDTH-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] mul_p;
	logic signed [SW-1:0] sum;
	logic signed [YW-1:0] y, lo_ext, hi_ext;
	logic signed [XW-1:0] acc_sum;
	logic                 err_pos, err_neg;

	assign err_new = EW'(sample.target_value) - EW'(sample.measured_value);

	always_comb begin
		unique case (cmd.mul_sel)
			pidaw_pkg::MUL_P: begin
				mul_a = cfg.kp;
				mul_b = BW'(err_q);
			end
			pidaw_pkg::MUL_D: begin
				mul_a = cfg.kd;
				mul_b = BW'(diff_q);
			end
			pidaw_pkg::MUL_I: begin
				mul_a = cfg.ki;
				mul_b = BW'(acc_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Full-width signed product of the selected gain and operand.
	assign mul_p = mul_a * mul_b;

	// Exact sum of the three terms, floored to an integer by the shift.
	assign sum    = SW'(pd_q) + SW'(prod_q);
	assign y      = YW'(sum >>> pidaw_pkg::GAIN_FRAC_BITS);
	assign lo_ext = YW'(cfg.lo);
	assign hi_ext = YW'(cfg.hi);

	assign err_pos = (err_q > EW'(0));
	assign err_neg = err_q[EW-1];
	assign acc_sum = XW'(acc_q) + XW'(err_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			acc_q      <= '0;
		end else begin
			if (cmd.load) begin
				prev_err_q <= err_new;
			end
			if (cmd.acc_en && !hold_q) begin
				if (acc_sum > ACC_MAX) begin
					acc_q <= AW'(ACC_MAX);
				end else if (acc_sum < ACC_MIN) begin
					acc_q <= AW'(ACC_MIN);
				end else begin
					acc_q <= AW'(acc_sum);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q  <= err_new;
			diff_q <= DW'(err_new) - DW'(prev_err_q);
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.pd_load) begin
			pd_q <= prod_q;
		end else if (cmd.pd_add) begin
			pd_q <= pd_q + prod_q;
		end
		if (cmd.trial_en) begin
			hold_q <= ((y >= hi_ext) && err_pos) || ((y <= lo_ext) && err_neg);
		end
		if (cmd.out_load) begin
			// The lower limit wins when the limits cross.
			if (y < lo_ext) begin
				drive_q.drive_value  <= cfg.lo;
				drive_q.clamp_status <= pidaw_pkg::STATUS_LOW;
			end else if (y > hi_ext) begin
				drive_q.drive_value  <= cfg.hi;
				drive_q.clamp_status <= pidaw_pkg::STATUS_HIGH;
			end else begin
				drive_q.drive_value  <= pidaw_pkg::DATA_WIDTH'(y);
				drive_q.clamp_status <= pidaw_pkg::STATUS_WITHIN;
			end
		end
	end

	assign drive = drive_q;

endmodule
`default_nettype wire

@@ rtl/core/pidaw_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidaw_checker: port-level checks of the PID controller
// Watches the handshakes and payloads on the top level's ports.
// ----------------------------------------------------------------------------
module pidaw_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              sample_valid,
	input wire logic              sample_stall,
	input wire logic              drive_valid,
	input wire logic              drive_stall,
	input wire pidaw_pkg::drive_t drive
);

	logic sample_beat;

	assign sample_beat = sample_valid && !sample_stall;

	// A stalled drive beat stays offered and unchanged.
	a_drive_hold: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive_stall |=> drive_valid && $stable(drive))
		else $error("drive beat changed while stalled");

	// Clamp status never carries the unused code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> (drive.clamp_status == pidaw_pkg::STATUS_WITHIN ||
			drive.clamp_status == pidaw_pkg::STATUS_HIGH ||
			drive.clamp_status == pidaw_pkg::STATUS_LOW))
		else $error("undefined clamp status");

	// A sample keeps the input side busy for the whole computation.
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		sample_beat |=> sample_stall ##1 sample_stall ##1 sample_stall
			##1 sample_stall ##1 sample_stall ##1 sample_stall ##1 sample_stall)
		else $error("sample taken before the previous one finished");

	// A new drive beat appears only at the end of a computation.
	a_drive_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drive_valid) |-> $past(sample_stall))
		else $error("drive beat without a computation");

endmodule

bind pid_controller_antiwindup pidaw_checker u_pidaw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_stall (sample_stall),
	.drive_valid  (drive_valid),
	.drive_stall  (drive_stall),
	.drive        (drive)
);
`default_nettype wire
